/* hdl/cfq_pkg.sv */
// shared types and constants for the circular fifo queue
`default_nettype none

package cfq_pkg;

   localparam int VALUE_W     = 32;
   localparam int OCC_W       = 6;
   localparam int REQ_TUSER_W = 2;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - VALUE_W - OCC_W;

   typedef enum logic [1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_PEEK = 2'd2,
      OP_TRAV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

endpackage

`default_nettype wire

/* hdl/cfq_front.sv */
// request intake: decodes the operation and buffers commands in a two-entry queue
`default_nettype none

module cfq_front
   import cfq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,  // value
   input  wire logic [REQ_TUSER_W-1:0]  req_tuser,  // func
   output logic                         cmd_valid,
   output cmd_type                      cmd,
   input  wire logic                    cmd_pop
);

   localparam int QUEUE_DEPTH = 2;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic                push;
   cmd_type             decoded;

   always_comb begin
      decoded.value = req_tdata;
      case (req_tuser)
         OP_ENQ:  decoded.op = OP_ENQ;
         OP_DEQ:  decoded.op = OP_DEQ;
         OP_PEEK: decoded.op = OP_PEEK;
         default: decoded.op = OP_TRAV;
      endcase
   end

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

/* hdl/cfq_back.sv */
// command execution: ring storage, head and tail pointers, result register
`default_nettype none

module cfq_back
   import cfq_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    cmd_valid,
   input  wire cmd_type                 cmd,
   output logic                         cmd_pop,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,  // data, occupancy, zero pad
   output logic [RSP_TUSER_W-1:0]       rsp_tuser,  // status, is_empty
   output logic                         rsp_tlast
);

   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_HEAD,
      S_TRAV
   } state_type;

   logic signed [VALUE_W-1:0]  mem [DEPTH];
   logic signed [VALUE_W-1:0]  rd_data_ff;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic [IDX_W-1:0]           tail_ff, tail_in;
   logic [IDX_W-1:0]           ptr_ff, ptr_in;

   logic                       rsp_valid_ff;
   status_type                 rsp_status_ff;
   logic signed [VALUE_W-1:0]  rsp_data_ff;
   logic [OCC_W-1:0]           rsp_occ_ff;
   logic                       rsp_empty_ff;
   logic                       rsp_last_ff;

   logic                       rd_en, wr_en, load, out_free;
   logic [IDX_W-1:0]           rd_addr;
   logic                       empty, full;
   status_type                 res_status;
   logic signed [VALUE_W-1:0]  res_data;
   logic                       res_last;
   logic [IDX_W:0]             occ_next;

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign empty    = (head_ff == tail_ff);
   assign full     = (advance(tail_ff) == head_ff);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      ptr_in     = ptr_ff;
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      wr_en      = 1'b0;
      load       = 1'b0;
      cmd_pop    = 1'b0;
      res_status = ST_OK;
      res_data   = '0;
      res_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_ENQ) begin
                  if (out_free) begin
                     load    = 1'b1;
                     cmd_pop = 1'b1;
                     if (full) begin
                        res_status = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = advance(tail_ff);
                     end
                  end
               end else if (empty) begin
                  if (out_free) begin
                     load       = 1'b1;
                     cmd_pop    = 1'b1;
                     res_status = ST_EMPTY;
                  end
               end else begin
                  // fetch the head word into the read register; the head or traverse state emits it
                  rd_en    = 1'b1;
                  ptr_in   = head_ff;
                  state_in = (cmd.op == OP_TRAV) ? S_TRAV : S_HEAD;
               end
            end
         end
         S_HEAD: begin
            if (out_free) begin
               load     = 1'b1;
               cmd_pop  = 1'b1;
               res_data = rd_data_ff;
               state_in = S_IDLE;
               if (cmd.op == OP_DEQ) begin
                  head_in = advance(head_ff);
               end
            end
         end
         S_TRAV: begin
            if (out_free) begin
               load     = 1'b1;
               res_data = rd_data_ff;
               res_last = (advance(ptr_ff) == tail_ff);
               if (res_last) begin
                  cmd_pop  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  // read the next entry while this one goes out
                  ptr_in  = advance(ptr_ff);
                  rd_en   = 1'b1;
                  rd_addr = advance(ptr_ff);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ring distance after the operation
   always_comb begin
      occ_next = {1'b0, tail_in} - {1'b0, head_in};
      if (tail_in < head_in) begin
         occ_next = occ_next + (IDX_W + 1)'(DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         ptr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_data_ff   <= '0;
         rsp_occ_ff    <= '0;
         rsp_empty_ff  <= 1'b1;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         ptr_ff   <= ptr_in;
         if (load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= res_status;
            rsp_data_ff   <= res_data;
            rsp_occ_ff    <= OCC_W'(occ_next);
            rsp_empty_ff  <= (occ_next == '0);
            rsp_last_ff   <= res_last;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_occ_ff, rsp_data_ff};
   assign rsp_tuser  = {rsp_empty_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("write into a full ring");

   a_trav_ptr_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TRAV) |-> (ptr_ff != tail_ff))
      else $error("traverse pointer reached the tail");

   a_pop_ends_item: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (rsp_valid_ff && rsp_last_ff))
      else $error("command retired without a final result");

   a_read_then_emit: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff != S_IDLE))
      else $error("read data fetched but no emit state follows");

endmodule

`default_nettype wire

/* hdl/circular_fifo_queue.sv */
// top level of the circular fifo queue: intake queue plus execution unit
// usage:
//   req channel carries one request: req_tuser = func (0 enqueue, 1 dequeue,
//   2 peek, 3 traverse), req_tdata = the word to enqueue
//   rsp channel returns results: rsp_tdata = data word and occupancy,
//   rsp_tuser = status and empty flag, rsp_tlast marks the final result
//   of a request
//   the ring keeps one slot free, so it stores up to DEPTH-1 words
//   requests pass a two-entry intake queue, so the request side keeps
//   moving while the execution unit or the receiver is busy
//   enqueue and empty-queue results pass the intake queue and the result
//   register; dequeue and peek also pass the read register (one storage read)
//   enqueue finishes in the idle state, dequeue and peek also pass the head
//   state, and traverse emits one stored word at a time through the single storage read port
//   reset empties the ring (head = tail = 0) and drops queued requests
//   a stalled receiver holds the result register; execution waits while
//   the intake queue still takes up to two more requests
`default_nettype none

module circular_fifo_queue
   import cfq_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,  // [31:0] value
   input  wire logic [REQ_TUSER_W-1:0]  req_tuser,  // [1:0] func
   // result channel
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,  // [31:0] data, [37:32] occupancy, pad
   output logic [RSP_TUSER_W-1:0]       rsp_tuser,  // [1:0] status, [2] is_empty
   output logic                         rsp_tlast   // last result of the request
);

   // decoded command handed from intake to execution
   logic     cmd_valid;
   cmd_type  cmd;
   logic     cmd_pop;

   // intake: decode and buffer requests
   cfq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // execution: ring storage, pointers and result register
   cfq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* tb/circular_fifo_queue_tb.sv */
// self-checking testbench for the circular fifo queue with a class-based scoreboard
`default_nettype none

import cfq_pkg::*;

localparam int RING_DEPTH = 64;

// one result as the queue should return it
typedef struct {
   status_type        status;
   logic [VALUE_W-1:0] data;
   logic [OCC_W-1:0]   occupancy;
   logic               is_empty;
   logic               last;
} queue_result_type;

class fifo_scoreboard;
   logic [VALUE_W-1:0] ring [RING_DEPTH];
   int                 head;
   int                 tail;
   queue_result_type   expected_q [$];
   int                 errors;

   function new();
      head   = 0;
      tail   = 0;
      errors = 0;
   endfunction

   function int advance(int idx);
      return (idx == RING_DEPTH - 1) ? 0 : idx + 1;
   endfunction

   function int occupancy();
      return (tail + RING_DEPTH - head) % RING_DEPTH;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // occupancy and empty flag are taken from the ring after the operation
   function void push_result(status_type st, logic [VALUE_W-1:0] word, logic lst);
      queue_result_type r;
      r.status    = st;
      r.data      = word;
      r.occupancy = OCC_W'(occupancy());
      r.is_empty  = (occupancy() == 0);
      r.last      = lst;
      expected_q.push_back(r);
   endfunction

   // called once for every accepted request
   function void note_request(op_type op, logic [VALUE_W-1:0] value);
      int idx;
      int nxt;
      case (op)
         OP_ENQ: begin
            if (advance(tail) == head) begin
               push_result(ST_FULL, '0, 1'b1);
            end else begin
               ring[tail] = value;
               tail       = advance(tail);
               push_result(ST_OK, '0, 1'b1);
            end
         end
         OP_DEQ, OP_PEEK: begin
            if (head == tail) begin
               push_result(ST_EMPTY, '0, 1'b1);
            end else begin
               idx = head;
               if (op == OP_DEQ) head = advance(head);
               push_result(ST_OK, ring[idx], 1'b1);
            end
         end
         default: begin
            if (head == tail) begin
               push_result(ST_EMPTY, '0, 1'b1);
            end else begin
               // one result per stored word, oldest first
               idx = head;
               while (idx != tail) begin
                  nxt = advance(idx);
                  push_result(ST_OK, ring[idx], nxt == tail);
                  idx = nxt;
               end
            end
         end
      endcase
   endfunction

   function void compare_field(string name, logic [VALUE_W-1:0] want,
                               logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // called once for every accepted result
   function void check_result(logic [RSP_TDATA_W-1:0] tdata,
                              logic [RSP_TUSER_W-1:0] tuser, logic tlast);
      queue_result_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual tdata %h tuser %h tlast %b",
                  $time, tdata, tuser, tlast);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      compare_field("status", VALUE_W'(want.status), VALUE_W'(tuser[1:0]));
      compare_field("data", want.data, tdata[VALUE_W-1:0]);
      compare_field("occupancy", VALUE_W'(want.occupancy),
                    VALUE_W'(tdata[VALUE_W +: OCC_W]));
      compare_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(tuser[2]));
      compare_field("last", VALUE_W'(want.last), VALUE_W'(tlast));
   endfunction
endclass

module circular_fifo_queue_tb;

   localparam int MAX_GAP    = 18;
   localparam int LONG_HOLD  = 300;
   localparam int IDLE_LIMIT = 2000;
   localparam int RAND_ITEMS = 44;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [31:0] value
   logic [REQ_TUSER_W-1:0] req_tuser;   // [1:0] func
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [31:0] data, [37:32] occupancy, pad
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // [1:0] status, [2] is_empty
   logic                   rsp_tlast;

   fifo_scoreboard sb;

   // flat-out modes for either side, and a request for one long receiver stall
   bit req_burst;
   bit rsp_burst;
   bit rsp_hold_request;
   int rsp_wait;
   int idle_cycles;

   circular_fifo_queue #(.DEPTH(RING_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // receiver: random stall after each result, or one long hold on request
   always @(posedge clock) begin
      if (rsp_hold_request) begin
         rsp_hold_request = 1'b0;
         rsp_wait         = LONG_HOLD;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_wait = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_tready <= (rsp_wait == 0);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // watchdog on cycles where neither channel moves anything
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one request after a random gap and wait until it is taken;
   // tvalid stays high across back-to-back requests
   task automatic send_request(op_type op, logic [VALUE_W-1:0] value);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sb.note_request(op, value);
   endtask

   // sender pause until every expected result has come back
   task automatic wait_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // random words half of the time, otherwise an extreme
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // op mix leans toward filling or draining depending on the chunk
   function automatic op_type pick_op(bit fill_bias);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < (fill_bias ? 65 : 25)) return OP_ENQ;
      if (roll < 80) return OP_DEQ;
      if (roll < 92) return OP_PEEK;
      return OP_TRAV;
   endfunction

   initial begin
      bit fill_bias;
      sb               = new();
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = OP_ENQ;
      rsp_tready       = 1'b0;
      rsp_wait         = 0;
      rsp_hold_request = 1'b0;
      req_burst        = 1'b0;
      rsp_burst        = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty-queue answers for every reading operation
      send_request(OP_PEEK, $urandom);
      send_request(OP_DEQ, $urandom);
      send_request(OP_TRAV, $urandom);
      // extremes of the word
      send_request(OP_ENQ, 32'h7fff_ffff);
      send_request(OP_ENQ, 32'h8000_0000);
      send_request(OP_ENQ, 32'h0000_0000);
      send_request(OP_ENQ, 32'hffff_ffff);
      send_request(OP_ENQ, 32'h5555_5555);
      send_request(OP_ENQ, 32'haaaa_aaaa);
      send_request(OP_PEEK, $urandom);
      send_request(OP_TRAV, $urandom);
      send_request(OP_DEQ, $urandom);
      send_request(OP_DEQ, $urandom);
      send_request(OP_TRAV, $urandom);
      // single entry: traverse gives one result marked last
      send_request(OP_DEQ, $urandom);
      send_request(OP_DEQ, $urandom);
      send_request(OP_DEQ, $urandom);
      send_request(OP_TRAV, $urandom);
      send_request(OP_DEQ, $urandom);
      wait_results();

      // long receiver hold while requests keep coming: the block backs up
      // and the ring fills, then full reports and a traverse of every stored word
      req_burst        = 1'b1;
      rsp_hold_request = 1'b1;
      while (sb.occupancy() < RING_DEPTH - 1) send_request(OP_ENQ, pick_value());
      send_request(OP_ENQ, $urandom);
      send_request(OP_ENQ, $urandom);
      send_request(OP_TRAV, $urandom);
      send_request(OP_PEEK, $urandom);
      req_burst = 1'b0;
      wait_results();

      // random traffic in chunks, each with its own bias and pacing
      fill_bias = 1'b0;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 16 == 0) begin
            fill_bias = ($urandom_range(0, 1) == 1);
            req_burst = ($urandom_range(0, 3) == 0);
            rsp_burst = ($urandom_range(0, 3) == 0);
         end
         send_request(pick_op(fill_bias), pick_value());
      end

      wait_results();
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
